/* design/cbmt_pkg.sv */
package cbmt_pkg;

   // Request commands
   typedef enum logic [1:0] {
      CMD_INC   = 2'd0,
      CMD_DEC   = 2'd1,
      CMD_CLR   = 2'd2,
      CMD_QUERY = 2'd3
   } cbmt_cmd_type;

   localparam int unsigned IDX_W     = 10;
   localparam int unsigned VAL_W     = 16;
   localparam int unsigned HOLDERS_W = 11;

   typedef struct packed {
      cbmt_cmd_type      command;
      logic [IDX_W-1:0]  counter_index;
   } cbmt_req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] counter_value;
      logic signed [VAL_W-1:0] max_value;
      logic [HOLDERS_W-1:0]    max_holders;
   } cbmt_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } cbmt_state_type;

   // Datapath status seen by the sequencer
   typedef struct packed {
      logic accept;
      logic rescan;
      logic addr_last;
      logic out_free;
   } cbmt_status_type;

   // Sequencer controls to the datapath
   typedef struct packed {
      logic req_ready;
      logic clear_wr;
      logic update;
      logic scan_rd;
      logic addr_inc;
      logic addr_zero;
      logic load_rsp;
   } cbmt_ctrl_type;

endpackage

/* design/cbmt_ram.sv */
module cbmt_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/cbmt_cmp.sv */
// Shared two's-complement signed compare: a against b
module cbmt_cmp #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic signed [COUNT_BITS-1:0] a,
   input  logic signed [COUNT_BITS-1:0] b,
   output logic                         gt,
   output logic                         eq
);

   assign gt = a > b;
   assign eq = a == b;

endmodule

/* design/cbmt_ctrl.sv */
module cbmt_ctrl
   import cbmt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cbmt_status_type status,
   output cbmt_ctrl_type   ctrl
);

   cbmt_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.addr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (status.accept) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.rescan)        state_in = ST_SCAN;
            else if (status.out_free) state_in = ST_IDLE;
            else                      state_in = ST_FINISH;
         end
         ST_SCAN: begin
            if (status.addr_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctrl.clear_wr  = 1'b1;
            ctrl.addr_inc  = 1'b1;
            ctrl.addr_zero = status.addr_last;
         end
         ST_IDLE: begin
            ctrl.req_ready = 1'b1;
         end
         ST_UPDATE: begin
            ctrl.update   = 1'b1;
            ctrl.load_rsp = !status.rescan && status.out_free;
         end
         ST_SCAN: begin
            ctrl.scan_rd   = 1'b1;
            ctrl.addr_inc  = 1'b1;
            ctrl.addr_zero = status.addr_last;
         end
         ST_DRAIN: begin
         end
         ST_FINISH: begin
            ctrl.load_rsp = status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

/* design/counter_bank_max_tracker.sv */
// Bank of NUM_COUNTERS signed saturating event counters, COUNT_BITS wide, with a running
// record of the bank maximum and how many counters hold it. Each request (increment,
// decrement, reset to zero, query) returns one transaction: the addressed counter after the
// operation, the maximum, and its holder count. Indexes at or past NUM_COUNTERS change
// nothing and report a counter value of zero. After reset the block sweeps the counter RAM
// to zero, one entry per cycle, before the first request is taken. An ordinary request
// reads the counter RAM, then writes back and updates the record. When the last holder
// of the maximum drops, the bank is rescanned through the single RAM read port and one
// shared comparator. A finished result sits in an output register, so a new request can be
// taken while the previous transaction is still stalled on the response side.
module counter_bank_max_tracker
   import cbmt_pkg::*;
#(
   parameter int unsigned NUM_COUNTERS = 1024,
   parameter int unsigned COUNT_BITS   = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  cbmt_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output cbmt_rsp_type rsp_data
);

   localparam int unsigned AW  = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
   localparam int unsigned IW  = (AW > IDX_W) ? AW : IDX_W;
   localparam int unsigned HW  = $clog2(NUM_COUNTERS + 1);
   localparam int unsigned XVW = (COUNT_BITS > VAL_W) ? COUNT_BITS : VAL_W;
   localparam int unsigned XHW = (HW > HOLDERS_W) ? HW : HOLDERS_W;

   localparam logic signed [COUNT_BITS-1:0] VAL_TOP    = {1'b0, {(COUNT_BITS-1){1'b1}}};
   localparam logic signed [COUNT_BITS-1:0] VAL_BOTTOM = {1'b1, {(COUNT_BITS-1){1'b0}}};
   localparam logic [AW-1:0]                ADDR_LAST  = AW'(NUM_COUNTERS - 1);

   cbmt_status_type status;
   cbmt_ctrl_type   ctrl;

   // request capture
   cbmt_cmd_type  cmd_ff;
   logic [AW-1:0] idx_ff;
   logic          in_range_ff;
   logic [IW-1:0] req_idx_wide;
   logic          req_in_range;
   logic          accept;

   // sweep address shared by the clearing pass and the rescan
   logic [AW-1:0] addr_ff, addr_in;
   logic          scan_rd_ff;
   logic          scan_first_ff, scan_first_in;

   // maximum record
   logic signed [COUNT_BITS-1:0] max_ff, max_in;
   logic [HW-1:0]                holders_ff, holders_in;
   logic signed [COUNT_BITS-1:0] cur_val_ff, cur_val_in;

   // counter RAM
   logic                         ram_wr_en;
   logic [AW-1:0]                ram_wr_addr;
   logic [COUNT_BITS-1:0]        ram_wr_data;
   logic                         ram_rd_en;
   logic [AW-1:0]                ram_rd_addr;
   logic [COUNT_BITS-1:0]        ram_rd_data;

   // read-modify-write
   logic signed [COUNT_BITS-1:0] old_val;
   logic signed [COUNT_BITS-1:0] new_val;
   logic                         went_up;
   logic                         went_down;
   logic                         old_is_max;
   logic                         rescan;

   // shared comparator
   logic signed [COUNT_BITS-1:0] cmp_a;
   logic                         cmp_gt;
   logic                         cmp_eq;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   cbmt_rsp_type                 rsp_data_ff, rsp_data_in;
   logic signed [XVW-1:0]        cur_val_wide;
   logic signed [XVW-1:0]        max_wide;
   logic [XHW-1:0]               holders_wide;

   assign accept       = req_valid && ctrl.req_ready;
   assign req_stall    = !ctrl.req_ready;
   assign req_idx_wide = IW'(req_data.counter_index);
   assign req_in_range = 32'(req_data.counter_index) < 32'(NUM_COUNTERS);

   assign status.accept    = accept;
   assign status.rescan    = rescan;
   assign status.addr_last = addr_ff == ADDR_LAST;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   cbmt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= req_data.command;
         idx_ff      <= req_idx_wide[AW-1:0];
         in_range_ff <= req_in_range;
      end
   end

   // sweep address
   always_comb begin
      addr_in = addr_ff;
      if (ctrl.addr_zero)     addr_in = '0;
      else if (ctrl.addr_inc) addr_in = addr_ff + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff       <= '0;
         scan_rd_ff    <= 1'b0;
         scan_first_ff <= 1'b0;
      end else begin
         addr_ff       <= addr_in;
         scan_rd_ff    <= ctrl.scan_rd;
         scan_first_ff <= scan_first_in;
      end
   end

   // first scanned entry seeds the record
   always_comb begin
      scan_first_in = scan_first_ff;
      if (ctrl.update && rescan) scan_first_in = 1'b1;
      else if (scan_rd_ff)       scan_first_in = 1'b0;
   end

   // RAM ports
   assign ram_rd_en   = accept || ctrl.scan_rd;
   assign ram_rd_addr = ctrl.scan_rd ? addr_ff : req_idx_wide[AW-1:0];
   assign ram_wr_en   = ctrl.clear_wr || (ctrl.update && in_range_ff);
   assign ram_wr_addr = ctrl.clear_wr ? addr_ff : idx_ff;
   assign ram_wr_data = ctrl.clear_wr ? '0 : new_val;

   cbmt_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NUM_COUNTERS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // new counter value and direction of change
   assign old_val = ram_rd_data;

   always_comb begin
      new_val   = old_val;
      went_up   = 1'b0;
      went_down = 1'b0;
      case (cmd_ff)
         CMD_INC: begin
            if (old_val != VAL_TOP) begin
               new_val = old_val + COUNT_BITS'(1);
               went_up = 1'b1;
            end
         end
         CMD_DEC: begin
            if (old_val != VAL_BOTTOM) begin
               new_val   = old_val - COUNT_BITS'(1);
               went_down = 1'b1;
            end
         end
         CMD_CLR: begin
            new_val   = '0;
            went_up   = old_val[COUNT_BITS-1];
            went_down = !old_val[COUNT_BITS-1] && (old_val != '0);
         end
         default: begin
         end
      endcase
   end

   // one comparator against the record: the new value on update, RAM data on rescan
   assign cmp_a = ctrl.update ? new_val : signed'(ram_rd_data);

   cbmt_cmp #(
      .COUNT_BITS (COUNT_BITS)
   ) u_cmp (
      .a  (cmp_a),
      .b  (max_ff),
      .gt (cmp_gt),
      .eq (cmp_eq)
   );

   assign old_is_max = old_val == max_ff;
   assign rescan     = ctrl.update && in_range_ff && went_down && old_is_max &&
                       (holders_ff == HW'(1));

   // record update
   always_comb begin
      max_in     = max_ff;
      holders_in = holders_ff;
      cur_val_in = cur_val_ff;
      if (ctrl.update) begin
         cur_val_in = in_range_ff ? new_val : '0;
         if (in_range_ff) begin
            if (went_up) begin
               if (cmp_gt) begin
                  max_in     = new_val;
                  holders_in = HW'(1);
               end else if (cmp_eq) begin
                  holders_in = holders_ff + HW'(1);
               end
            end else if (went_down && old_is_max && (holders_ff != HW'(1))) begin
               holders_in = holders_ff - HW'(1);
            end
         end
      end else if (scan_rd_ff) begin
         if (scan_first_ff || cmp_gt) begin
            max_in     = signed'(ram_rd_data);
            holders_in = HW'(1);
         end else if (cmp_eq) begin
            holders_in = holders_ff + HW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff     <= '0;
         holders_ff <= HW'(NUM_COUNTERS);
      end else begin
         max_ff     <= max_in;
         holders_ff <= holders_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_val_ff <= cur_val_in;
   end

   // response: extend (values signed, holder count unsigned) or truncate to the port widths
   assign cur_val_wide = XVW'(cur_val_in);
   assign max_wide     = XVW'(max_in);
   assign holders_wide = XHW'(holders_in);

   always_comb begin
      rsp_data_in.counter_value = cur_val_wide[VAL_W-1:0];
      rsp_data_in.max_value     = max_wide[VAL_W-1:0];
      rsp_data_in.max_holders   = holders_wide[HOLDERS_W-1:0];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.load_rsp)      rsp_valid_in = 1'b1;
      else if (!rsp_stall)    rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
